[hw/rtl/lcls_pkg.sv]
// Types, codes and widths shared by the lock chamber leveling sequencer.
package lcls_pkg;

	localparam int unsigned CmdW   = 2;
	localparam int unsigned DoorW  = 3;
	localparam int unsigned LevelW = 3;
	localparam int unsigned PhaseW = 3;

	localparam logic [CmdW-1:0] CMD_NONE  = 2'd0;
	localparam logic [CmdW-1:0] CMD_OPEN  = 2'd1;
	localparam logic [CmdW-1:0] CMD_CLOSE = 2'd2;

	localparam logic [DoorW-1:0] DOOR_CLOSED  = 3'd0;
	localparam logic [DoorW-1:0] DOOR_OPENING = 3'd1;
	localparam logic [DoorW-1:0] DOOR_OPEN    = 3'd2;
	localparam logic [DoorW-1:0] DOOR_CLOSING = 3'd3;

	localparam logic [LevelW-1:0] LVL_LOW      = 3'd0;
	localparam logic [LevelW-1:0] LVL_BELOW_V2 = 3'd1;
	localparam logic [LevelW-1:0] LVL_ABOVE_V2 = 3'd2;
	localparam logic [LevelW-1:0] LVL_HIGH     = 3'd4;

	localparam logic [PhaseW-1:0] PH_IDLE        = 3'd0;
	localparam logic [PhaseW-1:0] PH_LOWER_CLOSE = 3'd1;
	localparam logic [PhaseW-1:0] PH_RAISE_CLOSE = 3'd2;
	localparam logic [PhaseW-1:0] PH_LOWERING    = 3'd3;
	localparam logic [PhaseW-1:0] PH_RAISING     = 3'd4;
	localparam logic [PhaseW-1:0] PH_LOWER_OPEN  = 3'd5;
	localparam logic [PhaseW-1:0] PH_RAISE_OPEN  = 3'd6;
	localparam logic [PhaseW-1:0] PH_DONE        = 3'd7;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_START = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [LevelW-1:0] water_level;
		logic [DoorW-1:0]  low_door_state;
		logic [DoorW-1:0]  high_door_state;
		logic              low_bottom_valve_open;
		logic              high_bottom_valve_open;
		logic              high_middle_valve_open;
		logic              high_top_valve_open;
	} in_item_t;

	typedef struct packed {
		logic              start_accepted;
		logic              busy_res;
		logic [PhaseW-1:0] phase;
		logic [CmdW-1:0]   low_door_cmd;
		logic [CmdW-1:0]   high_door_cmd;
		logic [CmdW-1:0]   low_bottom_valve_cmd;
		logic [CmdW-1:0]   high_bottom_valve_cmd;
		logic [CmdW-1:0]   high_middle_valve_cmd;
		logic [CmdW-1:0]   high_top_valve_cmd;
	} out_item_t;

	typedef struct packed {
		logic              active;
		logic [PhaseW-1:0] phase;
	} seq_state_t;

endpackage

[hw/rtl/lcls_stream_if.sv]
// Valid/ready stream channel carrying one payload item per handshake.
interface lcls_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/lcls_step.sv]
// Phase transition and door/valve command decode for one item.
module lcls_step (
	input  lcls_pkg::in_item_t   item,
	input  lcls_pkg::seq_state_t cur,
	output lcls_pkg::seq_state_t nxt,
	output lcls_pkg::out_item_t  res
);
	import lcls_pkg::*;

	logic            accepted;
	logic [CmdW-1:0] c_ldoor, c_hdoor, c_lbv, c_hbv, c_hmv, c_htv;

	always_comb begin
		nxt      = cur;
		accepted = 1'b0;
		c_ldoor  = CMD_NONE;
		c_hdoor  = CMD_NONE;
		c_lbv    = CMD_NONE;
		c_hbv    = CMD_NONE;
		c_hmv    = CMD_NONE;
		c_htv    = CMD_NONE;
		if (item.mode == MODE_START) begin
			if (!cur.active) begin
				if (item.water_level == LVL_HIGH) begin
					nxt.phase  = PH_LOWER_CLOSE;
					nxt.active = 1'b1;
					accepted   = 1'b1;
					if (item.high_door_state == DOOR_OPEN) c_hdoor = CMD_CLOSE;
				end else if (item.water_level == LVL_LOW) begin
					nxt.phase  = PH_RAISE_CLOSE;
					nxt.active = 1'b1;
					accepted   = 1'b1;
					if (item.low_door_state == DOOR_OPEN) c_ldoor = CMD_CLOSE;
				end
			end
		end else if (cur.active) begin
			unique case (cur.phase)
				PH_LOWER_CLOSE: begin
					if (item.high_door_state == DOOR_CLOSED)
						nxt.phase = PH_LOWERING;
					else if (item.high_door_state != DOOR_CLOSING)
						c_hdoor = CMD_CLOSE;
				end
				PH_RAISE_CLOSE: begin
					if (item.low_door_state == DOOR_CLOSED)
						nxt.phase = PH_RAISING;
					else if (item.low_door_state != DOOR_CLOSING)
						c_ldoor = CMD_CLOSE;
				end
				PH_LOWERING: begin
					if (item.water_level != LVL_LOW) begin
						if (!item.low_bottom_valve_open) c_lbv = CMD_OPEN;
					end else begin
						c_lbv     = CMD_CLOSE;
						c_ldoor   = CMD_OPEN;
						nxt.phase = PH_LOWER_OPEN;
					end
				end
				PH_RAISING: begin
					if (item.water_level == LVL_HIGH) begin
						c_hbv     = CMD_CLOSE;
						c_hmv     = CMD_CLOSE;
						c_htv     = CMD_CLOSE;
						c_hdoor   = CMD_OPEN;
						nxt.phase = PH_RAISE_OPEN;
					end else if (item.water_level == LVL_LOW
							|| item.water_level == LVL_BELOW_V2
							|| item.water_level == LVL_ABOVE_V2) begin
						if (!item.high_bottom_valve_open) c_hbv = CMD_OPEN;
						if (item.water_level != LVL_LOW && !item.high_middle_valve_open)
							c_hmv = CMD_OPEN;
						if (item.water_level == LVL_ABOVE_V2 && !item.high_top_valve_open)
							c_htv = CMD_OPEN;
					end
				end
				PH_LOWER_OPEN: begin
					if (item.low_door_state == DOOR_OPEN)
						nxt.phase = PH_DONE;
					else if (item.low_door_state != DOOR_OPENING)
						c_ldoor = CMD_OPEN;
				end
				PH_RAISE_OPEN: begin
					if (item.high_door_state == DOOR_OPEN)
						nxt.phase = PH_DONE;
					else if (item.high_door_state != DOOR_OPENING)
						c_hdoor = CMD_OPEN;
				end
				PH_DONE: begin
					nxt.phase  = PH_IDLE;
					nxt.active = 1'b0;
				end
				PH_IDLE: begin
					nxt = cur;
				end
			endcase
		end
	end

	assign res.start_accepted        = accepted;
	assign res.busy_res              = nxt.active;
	assign res.phase                 = nxt.phase;
	assign res.low_door_cmd          = c_ldoor;
	assign res.high_door_cmd         = c_hdoor;
	assign res.low_bottom_valve_cmd  = c_lbv;
	assign res.high_bottom_valve_cmd = c_hbv;
	assign res.high_middle_valve_cmd = c_hmv;
	assign res.high_top_valve_cmd    = c_htv;

endmodule

[hw/rtl/lock_chamber_level_sequencer_top.sv]
// Top level of the lock chamber leveling sequencer: input register, step logic, result register.
//
//  channel  | dir | payload     | handshake
//  ---------+-----+-------------+----------------
//  item     | in  | in_item_t   | valid / ready
//  result   | out | out_item_t  | valid / ready
//
// One item per cycle sustained unless the result stalls; result valid after the input register.
// The phase and busy registers advance when an item moves from the input register
// to the result register, so items are sequenced strictly in order.
// Reset clears the valid flags and the sequencer to idle.
// A stalled result holds; the input register still takes one more item behind it.
module lock_chamber_level_sequencer_top (
	input logic         clk,
	input logic         arst_n,
	lcls_stream_if.sink   item,
	lcls_stream_if.source result
);
	import lcls_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       out_valid_q;
	out_item_t  out_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	out_item_t  res_nxt;
	logic       advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) item_s1 <= item.data;
	end

	lcls_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{active: 1'b0, phase: PH_IDLE};
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= res_nxt;
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

`ifndef ASSERT_OFF
	a_busy_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.active == (state_q.phase != PH_IDLE))
		else $error("busy flag and phase disagree");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("sequencer state moved without an item");

	a_accept_enters_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.start_accepted |->
		(out_q.phase == PH_LOWER_CLOSE || out_q.phase == PH_RAISE_CLOSE))
		else $error("accepted start not in a close phase");

	a_result_from_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result appeared without an item");

	a_result_busy_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.busy_res == (out_q.phase != PH_IDLE)))
		else $error("result busy and phase disagree");
`endif

endmodule
